>>> design/bpma_pkg.sv
package bpma_pkg;

    // Default number of entries on the free-page stack.
    localparam int FREE_PAGES = 64;

    localparam logic [15:0] PROG_TOP_RESET = 16'hF000;
    localparam logic [15:0] MAP_BASE_RESET = 16'h0000;
    localparam logic [15:0] ADDR_ROUND     = 16'hFFFF;
    localparam logic [7:0]  NO_PAGE        = 8'h00;
    localparam logic [7:0]  FREE_SENTINEL  = 8'hFF;

    // Configuration register indexes.
    localparam int          CFG_IDX_W    = 1;
    localparam logic [0:0]  CFG_PROG_TOP = 1'b0;
    localparam logic [0:0]  CFG_MAP_BASE = 1'b1;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_FREE    = 2'd2,
        CMD_REALLOC = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOMEM    = 2'd1,
        STAT_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } state_t;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  page;
        logic [15:0] top;
        logic [15:0] length;
        logic [31:0] map_in;
    } req_t;

    typedef struct packed {
        logic [31:0] map_out;
        status_t     status;
        logic        vectors_moved;
        logic [7:0]  free_count;
    } rsp_t;

    // Number of 16K banks covered by an address, 1 to 4.
    function automatic logic [2:0] bank_count(input logic [15:0] addr,
                                              input logic [15:0] prog_top);
        logic [15:0] v;
        v = addr + ADDR_ROUND - prog_top;
        return {1'b0, v[15:14]} + 3'd1;
    endfunction

endpackage

>>> design/bpma_ram.sv
module bpma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/bank_page_map_allocator_core.sv
// Channel     | Ports                          | Handshake
// ------------+--------------------------------+------------------------------------
// command     | start, busy, request           | beat taken when start & !busy
// result      | done, result                   | one-cycle beat marked by done
// config      | cfg_write, cfg_index, cfg_data | write taken when cfg_write is high
//
// Every command walks the four slots in the run state, then the finishing state loads
// the result register that drives the result beat. The slot-by-slot walk is set
// by the single write port and single read port of the stack RAM, one push or pop each.
// A new command is taken in the cycle that shows the result beat. Reset clears the stack
// depth and the control state; the stack RAM needs no clearing because only entries
// below the depth are ever read. The receiver cannot stall, so no result is held back.
module bank_page_map_allocator_core #(
    parameter int FREE_PAGES = bpma_pkg::FREE_PAGES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bpma_pkg::req_t                 request,
    output logic                           done,
    output bpma_pkg::rsp_t                 result,
    input  logic                           cfg_write,
    input  logic [bpma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);

    localparam int DW = $clog2(FREE_PAGES + 1);
    localparam int AW = $clog2(FREE_PAGES);
    localparam logic [DW-1:0] FULL_DEPTH = DW'(FREE_PAGES);

    // Control state.
    bpma_pkg::state_t state_reg, state_next;
    logic [1:0]       idx_reg, idx_next;
    logic [DW-1:0]    depth_reg, depth_next;
    logic             pend_reg, pend_next;
    logic             done_reg, done_next;
    logic [15:0]      prog_top_reg, map_base_reg;

    // Per-command working registers.
    bpma_pkg::cmd_t    cmd_reg, cmd_next;
    logic [7:0]        page_reg, page_next;
    logic [3:0][7:0]   slot_reg, slot_next;
    logic [3:0]        mask_reg, mask_next;
    logic              pop_reg, pop_next;
    logic              shrink_reg, shrink_next;
    logic [2:0]        needed_reg, needed_next;
    bpma_pkg::status_t status_reg, status_next;
    logic              moved_reg, moved_next;
    logic [1:0]        pend_slot_reg, pend_slot_next;
    bpma_pkg::rsp_t    result_reg, result_next;

    // Stack RAM port signals.
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    // Decode of an incoming command.
    logic [2:0]        dec_needed, dec_have, dec_want;
    logic [3:0]        dec_mask;
    logic              dec_pop, dec_shrink, dec_moved;
    bpma_pkg::status_t dec_status;

    // Slots with the last popped page folded in, and the finished map.
    logic [3:0][7:0] slot_cap, slot_fin;
    logic [7:0]      fill;

    bpma_ram #(
        .WIDTH (8),
        .DEPTH (FREE_PAGES)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Work out which slots a command touches. Pops and pushes both walk the
    // slots in ascending order, so a mask of slots plus a direction says it all.
    always_comb
    begin
        dec_have   = bpma_pkg::bank_count(request.top, prog_top_reg);
        dec_want   = bpma_pkg::bank_count(request.length + map_base_reg, prog_top_reg);
        dec_needed = bpma_pkg::bank_count(request.top, prog_top_reg)
                     - ((request.page != bpma_pkg::NO_PAGE) ? 3'd1 : 3'd0);
        dec_mask   = 4'b0000;
        dec_pop    = 1'b0;
        dec_shrink = 1'b0;
        dec_moved  = 1'b0;
        dec_status = bpma_pkg::STAT_OK;
        unique case (request.command)
            bpma_pkg::CMD_ADD:
            begin
                dec_mask = 4'b0001;
            end
            bpma_pkg::CMD_ALLOC:
            begin
                dec_pop = 1'b1;
                if (DW'(dec_needed) > depth_reg)
                begin
                    dec_status = bpma_pkg::STAT_NOMEM;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        dec_mask[i] = 3'(i) < dec_needed;
                    end
                end
            end
            bpma_pkg::CMD_FREE:
            begin
                // A slot is returned only when it differs from the one before it.
                dec_mask[0] = request.map_in[7:0] != bpma_pkg::FREE_SENTINEL;
                for (int i = 1; i < 4; i++)
                begin
                    dec_mask[i] = request.map_in[8*i +: 8] != request.map_in[8*(i-1) +: 8];
                end
            end
            bpma_pkg::CMD_REALLOC:
            begin
                if (dec_want < dec_have)
                begin
                    dec_shrink = 1'b1;
                    dec_moved  = dec_want == 3'd1;
                    for (int i = 0; i < 4; i++)
                    begin
                        dec_mask[i] = (3'(i + 1) >= dec_want) && (3'(i + 1) < dec_have);
                    end
                end
                else if (dec_want > dec_have)
                begin
                    dec_pop = 1'b1;
                    if (DW'(dec_want - dec_have) > depth_reg)
                    begin
                        dec_status = bpma_pkg::STAT_NOMEM;
                    end
                    else
                    begin
                        dec_moved = 1'b1;
                        for (int i = 0; i < 4; i++)
                        begin
                            dec_mask[i] = (3'(i + 1) >= dec_have) && (3'(i + 1) < dec_want);
                        end
                    end
                end
            end
            default:
            begin
                dec_mask = 4'b0000;
            end
        endcase
    end

    // A popped page lands in the cycle after its read was issued.
    always_comb
    begin
        slot_cap = slot_reg;
        if (pend_reg)
        begin
            slot_cap[pend_slot_reg] = rd_data;
        end
    end

    // Build the final map once every pop has landed.
    always_comb
    begin
        fill     = (page_reg != bpma_pkg::NO_PAGE) ? page_reg
                                                   : slot_cap[2'(needed_reg - 3'd1)];
        slot_fin = slot_cap;
        unique case (cmd_reg)
            bpma_pkg::CMD_ADD, bpma_pkg::CMD_FREE:
            begin
                slot_fin = '0;
            end
            bpma_pkg::CMD_ALLOC:
            begin
                if (status_reg == bpma_pkg::STAT_OK)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (3'(i) >= needed_reg)
                        begin
                            slot_fin[i] = fill;
                        end
                    end
                end
            end
            bpma_pkg::CMD_REALLOC:
            begin
                // Slot 3 is never released by a shrink, so it is still intact here.
                if (shrink_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (mask_reg[i])
                        begin
                            slot_fin[i] = slot_cap[3];
                        end
                    end
                end
            end
            default:
            begin
                slot_fin = slot_cap;
            end
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpma_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = bpma_pkg::S_RUN;
                end
            end
            bpma_pkg::S_RUN:
            begin
                if (idx_reg == 2'd3)
                begin
                    state_next = bpma_pkg::S_FIN;
                end
            end
            bpma_pkg::S_FIN:
            begin
                state_next = bpma_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bpma_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and RAM control for each state.
    always_comb
    begin
        idx_next       = idx_reg;
        depth_next     = depth_reg;
        pend_next      = 1'b0;
        pend_slot_next = pend_slot_reg;
        done_next      = 1'b0;
        cmd_next       = cmd_reg;
        page_next      = page_reg;
        slot_next      = slot_cap;
        mask_next      = mask_reg;
        pop_next       = pop_reg;
        shrink_next    = shrink_reg;
        needed_next    = needed_reg;
        status_next    = status_reg;
        moved_next     = moved_reg;
        result_next    = result_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        unique case (state_reg)
            bpma_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = request.command;
                    page_next   = request.page;
                    slot_next   = request.map_in;
                    mask_next   = dec_mask;
                    pop_next    = dec_pop;
                    shrink_next = dec_shrink;
                    needed_next = dec_needed;
                    status_next = dec_status;
                    moved_next  = dec_moved;
                    idx_next    = 2'd0;
                end
            end
            bpma_pkg::S_RUN:
            begin
                if (mask_reg[idx_reg])
                begin
                    if (pop_reg)
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = AW'(depth_reg - DW'(1));
                        depth_next     = depth_reg - DW'(1);
                        pend_next      = 1'b1;
                        pend_slot_next = idx_reg;
                    end
                    else if (depth_reg == FULL_DEPTH)
                    begin
                        status_next = bpma_pkg::STAT_OVERFLOW;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = AW'(depth_reg);
                        wr_data    = (cmd_reg == bpma_pkg::CMD_ADD) ? page_reg
                                                                    : slot_reg[idx_reg];
                        depth_next = depth_reg + DW'(1);
                    end
                end
                idx_next = idx_reg + 2'd1;
            end
            bpma_pkg::S_FIN:
            begin
                result_next.map_out       = slot_fin;
                result_next.status        = status_reg;
                result_next.vectors_moved = moved_reg;
                result_next.free_count    = 8'(depth_reg);
                done_next                 = 1'b1;
            end
            default:
            begin
                idx_next = 2'd0;
            end
        endcase
    end

    assign busy   = state_reg != bpma_pkg::S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bpma_pkg::S_IDLE;
            idx_reg      <= 2'd0;
            depth_reg    <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
            prog_top_reg <= bpma_pkg::PROG_TOP_RESET;
            map_base_reg <= bpma_pkg::MAP_BASE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            depth_reg <= depth_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    bpma_pkg::CFG_PROG_TOP: prog_top_reg <= cfg_data;
                    bpma_pkg::CFG_MAP_BASE: map_base_reg <= cfg_data;
                    default:                prog_top_reg <= prog_top_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        page_reg      <= page_next;
        slot_reg      <= slot_next;
        mask_reg      <= mask_next;
        pop_reg       <= pop_next;
        shrink_reg    <= shrink_next;
        needed_reg    <= needed_next;
        status_reg    <= status_next;
        moved_reg     <= moved_next;
        pend_slot_reg <= pend_slot_next;
        result_reg    <= result_next;
    end

endmodule

>>> tb/sv/tb_bank_page_map_allocator_core.sv
`timescale 1ns / 1ps

module tb_bank_page_map_allocator_core;

    import bpma_pkg::*;

    // Random items drawn per register setting, on top of the directed opening.
    localparam int ITEMS_PER_PHASE = 386;
    localparam int PHASES          = 5;
    // Cycles without any accepted beat before the run is declared hung. The
    // longest quiet stretch of a correct run is a full sender gap plus the
    // time one command takes, or a drain pause plus two register writes.
    localparam int STALL_LIMIT     = 1000;
    // Cycles allowed after the last result before registers change or the run ends.
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 10;

    // Command mixes used by the random generator.
    localparam int MIX_NORMAL = 0;
    localparam int MIX_FILL   = 1;
    localparam int MIX_DRAIN  = 2;

    // A map that the testbench currently holds, with the top address it was
    // built for, so that later free and realloc beats use well-formed maps.
    typedef struct {
        logic [31:0] map;
        logic [15:0] top;
    } held_map_t;

    // Scoreboard: keeps its own copy of the free-page stack and the two
    // registers, works out the result of every accepted command, and checks
    // each result beat against the oldest outstanding prediction.
    class page_map_scoreboard;
        logic [7:0]  stack_pages [FREE_PAGES];
        int unsigned depth;
        logic [15:0] prog_top;
        logic [15:0] map_base;
        rsp_t        pending [$];
        held_map_t   held_maps [$];
        int unsigned errors;
        int unsigned beats;
        int unsigned cmd_seen [4];
        int unsigned nomem_seen;
        int unsigned overflow_seen;

        function new();
            prog_top      = PROG_TOP_RESET;
            map_base      = MAP_BASE_RESET;
            depth         = 0;
            errors        = 0;
            beats         = 0;
            nomem_seen    = 0;
            overflow_seen = 0;
            foreach (cmd_seen[i])
                cmd_seen[i] = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [15:0] value);
            if (index == CFG_PROG_TOP)
                prog_top = value;
            else
                map_base = value;
        endfunction

        // Number of 16K banks from the start of process space up to addr.
        function int unsigned banks(logic [15:0] addr);
            logic [15:0] span;
            span = addr - prog_top - 16'd1;
            return int'(span[15:14]) + 1;
        endfunction

        // A push onto a full stack is dropped and reported to the caller.
        function bit push_page(logic [7:0] pg);
            if (depth >= FREE_PAGES)
                return 1'b0;
            stack_pages[depth] = pg;
            depth++;
            return 1'b1;
        endfunction

        function logic [7:0] pop_page();
            if (depth == 0)
                return NO_PAGE;
            depth--;
            return stack_pages[depth];
        endfunction

        // Predicts the result of one accepted command. Tracked commands come
        // from the well-formed generator and keep the list of held maps current.
        function void note_command(req_t r, bit tracked);
            logic [7:0]  slot [4];
            logic [7:0]  fill;
            logic [7:0]  last;
            logic [15:0] size_addr;
            int unsigned needed;
            int unsigned have;
            int unsigned grow_to;
            rsp_t        due;
            for (int i = 0; i < 4; i++)
                slot[i] = r.map_in[8*i +: 8];
            due        = '0;
            due.status = STAT_OK;
            case (r.command)
                CMD_ADD:
                begin
                    if (!push_page(r.page))
                        due.status = STAT_OVERFLOW;
                end
                CMD_ALLOC:
                begin
                    needed = banks(r.top);
                    if (r.page != NO_PAGE)
                        needed--;
                    if (needed > depth)
                    begin
                        due.status  = STAT_NOMEM;
                        due.map_out = r.map_in;
                    end
                    else
                    begin
                        for (int i = 0; i < needed; i++)
                            slot[i] = pop_page();
                        // Without a common page the last popped page fills the rest.
                        fill = (r.page != NO_PAGE) ? r.page : slot[needed - 1];
                        for (int i = needed; i < 4; i++)
                            slot[i] = fill;
                        due.map_out = {slot[3], slot[2], slot[1], slot[0]};
                        if (tracked)
                            held_maps.push_back('{due.map_out, r.top});
                    end
                end
                CMD_FREE:
                begin
                    // Repeated slots share one page; slot 0 is compared with the
                    // sentinel so an unused slot 0 is never pushed.
                    last = FREE_SENTINEL;
                    for (int i = 0; i < 4; i++)
                    begin
                        if (slot[i] != last)
                        begin
                            if (!push_page(slot[i]))
                                due.status = STAT_OVERFLOW;
                            last = slot[i];
                        end
                    end
                end
                default:
                begin
                    have        = banks(r.top);
                    size_addr   = r.length + map_base;
                    grow_to     = banks(size_addr);
                    due.map_out = r.map_in;
                    if (grow_to < have)
                    begin
                        // Shrink: release the banks below the common slot.
                        for (int i = grow_to; i < have; i++)
                        begin
                            if (!push_page(slot[i - 1]))
                                due.status = STAT_OVERFLOW;
                            slot[i - 1] = slot[3];
                        end
                        due.vectors_moved = (grow_to == 1);
                        due.map_out       = {slot[3], slot[2], slot[1], slot[0]};
                    end
                    else if (grow_to > have)
                    begin
                        if (grow_to - have <= depth)
                        begin
                            for (int i = have; i < grow_to; i++)
                                slot[i - 1] = pop_page();
                            due.vectors_moved = 1'b1;
                            due.map_out       = {slot[3], slot[2], slot[1], slot[0]};
                        end
                        else
                            due.status = STAT_NOMEM;
                    end
                    if (tracked)
                        held_maps.push_back('{due.map_out,
                                              (due.status == STAT_NOMEM) ? r.top : size_addr});
                end
            endcase
            due.free_count = 8'(depth);
            cmd_seen[r.command]++;
            if (due.status == STAT_NOMEM)
                nomem_seen++;
            if (due.status == STAT_OVERFLOW)
                overflow_seen++;
            pending.push_back(due);
        endfunction

        function void check_result(rsp_t got);
            rsp_t due;
            beats++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result beat %0d arrived with no command outstanding: %p",
                             $realtime, beats, got);
                return;
            end
            due = pending.pop_front();
            if (got.map_out !== due.map_out || got.status !== due.status ||
                got.vectors_moved !== due.vectors_moved || got.free_count !== due.free_count)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: beat %0d mismatch: map_out %h/%h status %0d/%0d moved %b/%b free %0d/%0d (expected/actual)",
                             $realtime, beats, due.map_out, got.map_out, due.status, got.status,
                             due.vectors_moved, got.vectors_moved, due.free_count, got.free_count);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    req_t                 request;
    logic                 done;
    rsp_t                 result;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    page_map_scoreboard sb;
    // Mirrors the value last scheduled on start, so that start is never
    // lowered and raised again within one time step.
    bit                 start_high;
    // When set, the sender presents each command back to back.
    bit                 no_idle;

    bank_page_map_allocator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result beats last one cycle and cannot be held off, so each one is
    // checked at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // Watchdog: any accepted command or result beat restarts the count.
    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timed out after %0d cycles without a beat", STALL_LIMIT);
        $display("tb_bank_page_map_allocator_core NOT OK");
        $finish;
    end

    function automatic req_t command_beat(cmd_t cmd, logic [7:0] pg, logic [15:0] top,
                                          logic [15:0] length, logic [31:0] map_in);
        req_t r;
        r.command = cmd;
        r.page    = pg;
        r.top     = top;
        r.length  = length;
        r.map_in  = map_in;
        return r;
    endfunction

    // Mostly well-formed traffic: allocated maps come back as free or realloc
    // commands with the top address they were built for. A quarter of the
    // commands are fully random noise.
    function automatic void make_request(int mix, output req_t r, output bit tracked);
        int unsigned pick;
        int unsigned add_w;
        int unsigned alloc_w;
        int unsigned free_w;
        int unsigned idx;
        held_map_t   held;
        r.command = cmd_t'($urandom_range(0, 3));
        r.page    = 8'($urandom);
        r.top     = 16'($urandom);
        r.length  = 16'($urandom);
        r.map_in  = $urandom;
        tracked   = 1'b0;
        if ($urandom_range(0, 3) == 0)
            return;
        tracked = 1'b1;
        case (mix)
            MIX_FILL:
            begin
                add_w   = 70;
                alloc_w = 10;
                free_w  = 15;
            end
            MIX_DRAIN:
            begin
                add_w   = 10;
                alloc_w = 60;
                free_w  = 10;
            end
            default:
            begin
                add_w   = 30;
                alloc_w = 30;
                free_w  = 20;
            end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < add_w)
            r.command = CMD_ADD;
        else if (pick < add_w + alloc_w || sb.held_maps.size() == 0)
        begin
            r.command = CMD_ALLOC;
            if ($urandom_range(0, 1) == 0)
                r.page = NO_PAGE;
        end
        else
        begin
            idx  = $urandom_range(0, sb.held_maps.size() - 1);
            held = sb.held_maps[idx];
            sb.held_maps.delete(idx);
            r.map_in  = held.map;
            r.top     = held.top;
            r.command = (pick < add_w + alloc_w + free_w) ? CMD_FREE : CMD_REALLOC;
        end
    endfunction

    // Presents one command and returns at the edge that accepts it, with
    // start still high so that a back-to-back command needs no extra step.
    task automatic send_command(input req_t r, input bit tracked);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap != 0 && start_high)
        begin
            start <= 1'b0;
            start_high = 1'b0;
        end
        repeat (gap) @(posedge clk);
        start   <= 1'b1;
        start_high = 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(r, tracked);
    endtask

    // Stops sending and waits until every outstanding result has been seen.
    task automatic wait_for_results();
        if (start_high)
        begin
            start <= 1'b0;
            start_high = 1'b0;
        end
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers on consecutive edges; only called while idle.
    task automatic write_registers(input logic [15:0] top_addr, input logic [15:0] base);
        cfg_write <= 1'b1;
        cfg_index <= CFG_PROG_TOP;
        cfg_data  <= top_addr;
        @(posedge clk);
        sb.set_register(CFG_PROG_TOP, top_addr);
        cfg_index <= CFG_MAP_BASE;
        cfg_data  <= base;
        @(posedge clk);
        sb.set_register(CFG_MAP_BASE, base);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        req_t        r;
        bit          tracked;
        int          mix;
        logic [15:0] top_addr;
        logic [15:0] base;
        sb         = new();
        start_high = 1'b0;
        no_idle    = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_PROG_TOP;
        cfg_data   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset settings, where addresses 0xF001
        // through 0x3000 need one bank and 0xF000 needs all four.
        // Allocation with an empty stack runs out of memory.
        send_command(command_beat(CMD_ALLOC, NO_PAGE, 16'hF000, 16'h0000, 32'hAAAA5555), 0);
        // A common page with a one-bank top needs no page at all.
        send_command(command_beat(CMD_ALLOC, 8'h40, 16'hF001, 16'hFFFF, 32'h5555AAAA), 0);
        // Slot 0 holding the sentinel is never pushed, nor are its repeats.
        send_command(command_beat(CMD_FREE, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF), 0);
        send_command(command_beat(CMD_FREE, NO_PAGE, 16'h0000, 16'h0000, 32'h000000FF), 0);
        send_command(command_beat(CMD_ADD, 8'h01, 16'h0000, 16'h0000, 32'h00000000), 0);
        send_command(command_beat(CMD_ADD, 8'h80, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF), 0);
        send_command(command_beat(CMD_ADD, 8'hFF, 16'h5555, 16'hAAAA, 32'h5A5A5A5A), 0);
        send_command(command_beat(CMD_ADD, 8'h00, 16'hAAAA, 16'h5555, 32'hA5A5A5A5), 0);
        send_command(command_beat(CMD_ADD, 8'h55, 16'h8000, 16'h0001, 32'h80000001), 0);
        send_command(command_beat(CMD_ADD, 8'hAA, 16'h0001, 16'h8000, 32'h00010000), 0);
        send_command(command_beat(CMD_ADD, 8'h7F, 16'h7FFF, 16'h7FFF, 32'h7FFFFFFF), 0);
        send_command(command_beat(CMD_ADD, 8'hFE, 16'hFFFE, 16'hFFFE, 32'hFFFFFFFE), 0);
        // Four banks, then two banks filled with the last page popped.
        send_command(command_beat(CMD_ALLOC, NO_PAGE, 16'hF000, 16'h0000, 32'h0), 0);
        send_command(command_beat(CMD_ALLOC, NO_PAGE, 16'h3001, 16'h0000, 32'h0), 0);
        // Three pages under a common page empties the stack.
        send_command(command_beat(CMD_ALLOC, 8'h33, 16'hF000, 16'h0000, 32'h0), 0);
        // Growing with too few free pages leaves the map alone.
        send_command(command_beat(CMD_REALLOC, NO_PAGE, 16'h0000, 16'hF000, 32'h11223344), 0);
        send_command(command_beat(CMD_FREE, NO_PAGE, 16'h0000, 16'h0000, 32'h04030202), 0);
        // Realloc: same size, grow from one to three banks, shrink to one
        // bank, and shrink from four banks to two.
        send_command(command_beat(CMD_REALLOC, NO_PAGE, 16'h0000, 16'h0000, 32'h12345678), 0);
        send_command(command_beat(CMD_REALLOC, NO_PAGE, 16'h0000, 16'h7001, 32'h99000000), 0);
        send_command(command_beat(CMD_REALLOC, NO_PAGE, 16'hF000, 16'h0000, 32'h44332211), 0);
        send_command(command_beat(CMD_REALLOC, NO_PAGE, 16'hF000, 16'h3001, 32'h88776655), 0);
        send_command(command_beat(CMD_ADD, NO_PAGE, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF), 0);

        // Random phases, each under its own register setting. The fill mix
        // drives the stack into overflow; the drain mix runs it out of pages.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                1:
                begin
                    top_addr = 16'h4000;
                    base     = 16'hFFFF;
                    mix      = MIX_FILL;
                end
                2:
                begin
                    top_addr = 16'hFFFF;
                    base     = 16'h0000;
                    mix      = MIX_DRAIN;
                end
                3:
                begin
                    top_addr = 16'($urandom_range(16'h4000, 16'hFFFF));
                    base     = 16'($urandom);
                    mix      = MIX_NORMAL;
                end
                4:
                begin
                    top_addr = PROG_TOP_RESET;
                    base     = 16'h8000;
                    mix      = MIX_FILL;
                end
                default:
                begin
                    top_addr = PROG_TOP_RESET;
                    base     = MAP_BASE_RESET;
                    mix      = MIX_NORMAL;
                end
            endcase
            if (p > 0)
            begin
                wait_for_results();
                write_registers(top_addr, base);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 59) == 0)
                    no_idle = !no_idle;
                // Now and then the sender holds off until the block is empty.
                if ($urandom_range(0, 149) == 0)
                    wait_for_results();
                make_request(mix, r, tracked);
                send_command(r, tracked);
            end
        end

        wait_for_results();
        $display("Checked %0d result beats: %0d add, %0d allocate, %0d free, %0d realloc commands",
                 sb.beats, sb.cmd_seen[CMD_ADD], sb.cmd_seen[CMD_ALLOC],
                 sb.cmd_seen[CMD_FREE], sb.cmd_seen[CMD_REALLOC]);
        $display("over %0d register settings; %0d out of memory, %0d stack overflow, %0d mismatches",
                 PHASES, sb.nomem_seen, sb.overflow_seen, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_bank_page_map_allocator_core OK");
        else
            $display("tb_bank_page_map_allocator_core NOT OK");
        $finish;
    end

endmodule
